/* hw/rtl/hel_pkg.sv */
`timescale 1ns / 1ps

package hel_pkg;

    localparam int DATA_W       = 32;
    localparam int LOSS_W       = 52;
    localparam int MAX_ELEMENTS = 1048576;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int Q_PTR_W      = 2;
    localparam int Q_DEPTH      = 2 ** Q_PTR_W;
    localparam int DIV_STEPS    = LOSS_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 1'b1;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_SUM  = 2'd2;

    localparam logic signed [DATA_W-1:0] MARGIN_RESET = 32'sd65536;
    localparam logic [1:0]               MODE_RESET   = MODE_MEAN;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] target;
        logic                     last_element;
    } hel_in_t;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic              is_last;
    } hel_out_t;

    typedef enum logic [1:0] {
        OP_EMIT      = 2'd0,
        OP_ACC       = 2'd1,
        OP_SUM_LAST  = 2'd2,
        OP_MEAN_LAST = 2'd3
    } hel_op_t;

    typedef struct packed {
        hel_op_t           op;
        logic              is_last;
        logic [DATA_W-1:0] loss;
    } hel_cmd_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DIV  = 2'd1,
        ST_HOLD = 2'd2
    } hel_state_t;

endpackage

/* hw/rtl/hinge_embedding_loss_reduce.sv */
// Hinge embedding loss with none / mean / sum reduction, Q16.16 in, 16 fraction bits out.
// Throughput: one element per cycle unless the queue fills behind a divide or an untaken result.
// Result path: command queue, then result register; mean results pass the divider between them.
// The mean divide is a restoring divider: one quotient bit per cycle.
// Reset (rst_n, async, active low): margin = 1.0, mode = mean, sum/count cleared, queues empty.
`timescale 1ns / 1ps

module hinge_embedding_loss_reduce (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: index 0 margin, index 1 reduction mode
    input  logic                            cfg_we,
    input  logic [hel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hel_pkg::DATA_W-1:0]      cfg_data,
    // element input, a transfer when push && !full
    input  logic                            push,
    output logic                            full,
    input  hel_pkg::hel_in_t                in_item,
    // results, a transfer when pop && !empty
    output logic                            empty,
    input  logic                            pop,
    output hel_pkg::hel_out_t               out_item
);

    // Front: holds config, computes the element loss and tags each element with
    // what the back end must do (emit, accumulate, finish sum, finish mean).
    // Command queue: four entries, decouples the front from a divide or a full
    // result register. Back: saturating accumulator, bit-serial divider and a
    // one-entry result register that keeps accepting accumulate work while a
    // result waits to be taken.

    logic              cmd_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    hel_pkg::hel_cmd_t cmd_in;
    hel_pkg::hel_cmd_t cmd_out;

    assign full = q_full;

    hel_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .q_full    (q_full),
        .in_item   (in_item),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    hel_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (cmd_in),
        .rd_en    (q_pop),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_cmd   (cmd_out)
    );

    hel_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (cmd_out),
        .cmd_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

/* hw/rtl/hel_front.sv */
`timescale 1ns / 1ps

module hel_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hel_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hel_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 push,
    input  logic                                 q_full,
    input  hel_pkg::hel_in_t                     in_item,
    output logic                                 cmd_push,
    output hel_pkg::hel_cmd_t                    cmd
);

    logic signed [hel_pkg::DATA_W-1:0] margin_reg;
    logic [1:0]                        mode_reg;
    logic signed [hel_pkg::DATA_W:0]   diff;
    logic                              loss_pos;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            margin_reg <= hel_pkg::MARGIN_RESET;
            mode_reg   <= hel_pkg::MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hel_pkg::CFG_MARGIN: margin_reg <= cfg_data;
                hel_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // margin - sample is exact in 33 bits; positive result fits in 32
    always_comb
    begin
        if (in_item.target > 0)
            diff = {margin_reg[hel_pkg::DATA_W-1], margin_reg}
                 - {in_item.sample[hel_pkg::DATA_W-1], in_item.sample};
        else
            diff = {in_item.sample[hel_pkg::DATA_W-1], in_item.sample};
        loss_pos = (diff > 0);
    end

    assign cmd_push = push && !q_full;

    always_comb
    begin
        cmd.loss    = loss_pos ? diff[hel_pkg::DATA_W-1:0] : '0;
        cmd.is_last = in_item.last_element;
        priority if (mode_reg == hel_pkg::MODE_NONE)
            cmd.op = hel_pkg::OP_EMIT;
        else if (!in_item.last_element)
            cmd.op = hel_pkg::OP_ACC;
        else if (mode_reg == hel_pkg::MODE_MEAN)
            cmd.op = hel_pkg::OP_MEAN_LAST;
        else
            cmd.op = hel_pkg::OP_SUM_LAST;   // sum, and the unused code
    end

endmodule

/* hw/rtl/hel_cmdq.sv */
`timescale 1ns / 1ps

module hel_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  hel_pkg::hel_cmd_t wr_cmd,
    input  logic              rd_en,
    output logic              full,
    output logic              rd_valid,
    output hel_pkg::hel_cmd_t rd_cmd
);

    hel_pkg::hel_cmd_t           entry_reg [hel_pkg::Q_DEPTH];
    logic [hel_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [hel_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [hel_pkg::Q_PTR_W:0]   count_reg;

    assign full     = (count_reg == (hel_pkg::Q_PTR_W + 1)'(hel_pkg::Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en))
        else $error("cmdq write while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("cmdq read while empty");
`endif

endmodule

/* hw/rtl/hel_back.sv */
`timescale 1ns / 1ps

module hel_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  hel_pkg::hel_cmd_t cmd,
    output logic              cmd_pop,
    input  logic              pop,
    output logic              empty,
    output hel_pkg::hel_out_t out_item
);

    localparam logic [hel_pkg::CNT_W-1:0] CNT_MAX =
        hel_pkg::CNT_W'(hel_pkg::MAX_ELEMENTS);
    localparam logic [hel_pkg::DIV_CNT_W-1:0] STEP_LAST =
        hel_pkg::DIV_CNT_W'(hel_pkg::DIV_STEPS - 1);

    hel_pkg::hel_state_t state_reg, state_next;

    logic [hel_pkg::LOSS_W-1:0]    sum_reg;
    logic [hel_pkg::CNT_W-1:0]     cnt_reg;
    logic [hel_pkg::LOSS_W-1:0]    quo_reg;
    logic [hel_pkg::CNT_W-1:0]     rem_reg;
    logic [hel_pkg::CNT_W-1:0]     dvs_reg;
    logic [hel_pkg::DIV_CNT_W-1:0] step_reg;
    logic                          out_valid_reg;
    hel_pkg::hel_out_t             out_reg;

    logic [hel_pkg::LOSS_W:0]   sum_add;
    logic [hel_pkg::LOSS_W-1:0] sum_sat;
    logic [hel_pkg::CNT_W-1:0]  cnt_inc;
    logic [hel_pkg::CNT_W:0]    trial;
    logic                       trial_ge;
    logic                       slot_free;

    logic out_load, out_from_div, acc_update, acc_clear, div_start;

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;
    assign slot_free = !out_valid_reg || pop;

    // saturating add of the incoming loss, saturating count
    assign sum_add = {1'b0, sum_reg} + (hel_pkg::LOSS_W + 1)'(cmd.loss);
    assign sum_sat = sum_add[hel_pkg::LOSS_W] ? '1 : sum_add[hel_pkg::LOSS_W-1:0];
    assign cnt_inc = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // one restoring step per cycle
    assign trial    = {rem_reg, quo_reg[hel_pkg::LOSS_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hel_pkg::ST_RUN:
                if (cmd_valid && cmd.op == hel_pkg::OP_MEAN_LAST)
                    state_next = hel_pkg::ST_DIV;
            hel_pkg::ST_DIV:
                if (step_reg == STEP_LAST)
                    state_next = hel_pkg::ST_HOLD;
            hel_pkg::ST_HOLD:
                if (slot_free)
                    state_next = hel_pkg::ST_RUN;
            default:
                state_next = hel_pkg::ST_RUN;
        endcase
    end

    always_comb
    begin
        cmd_pop      = 1'b0;
        out_load     = 1'b0;
        out_from_div = 1'b0;
        acc_update   = 1'b0;
        acc_clear    = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            hel_pkg::ST_RUN:
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        hel_pkg::OP_ACC:
                        begin
                            cmd_pop    = 1'b1;
                            acc_update = 1'b1;
                        end
                        hel_pkg::OP_EMIT:
                            if (slot_free)
                            begin
                                cmd_pop   = 1'b1;
                                out_load  = 1'b1;
                                acc_clear = cmd.is_last;
                            end
                        hel_pkg::OP_SUM_LAST:
                            if (slot_free)
                            begin
                                cmd_pop   = 1'b1;
                                out_load  = 1'b1;
                                acc_clear = 1'b1;
                            end
                        hel_pkg::OP_MEAN_LAST:
                        begin
                            cmd_pop   = 1'b1;
                            div_start = 1'b1;
                            acc_clear = 1'b1;
                        end
                    endcase
                end
            hel_pkg::ST_DIV: ;
            hel_pkg::ST_HOLD:
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    out_from_div = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= hel_pkg::ST_RUN;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_clear)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (acc_update)
            begin
                sum_reg <= sum_sat;
                cnt_reg <= cnt_inc;
            end
            if (div_start)
                step_reg <= '0;
            else if (state_reg == hel_pkg::ST_DIV)
                step_reg <= step_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            quo_reg <= sum_sat;
            rem_reg <= '0;
            dvs_reg <= cnt_inc;
        end
        else if (state_reg == hel_pkg::ST_DIV)
        begin
            quo_reg <= {quo_reg[hel_pkg::LOSS_W-2:0], trial_ge};
            rem_reg <= trial_ge ? hel_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                                : trial[hel_pkg::CNT_W-1:0];
        end
        if (out_load)
        begin
            if (out_from_div)
            begin
                out_reg.loss    <= quo_reg;
                out_reg.is_last <= 1'b1;
            end
            else if (cmd.op == hel_pkg::OP_EMIT)
            begin
                out_reg.loss    <= hel_pkg::LOSS_W'(cmd.loss);
                out_reg.is_last <= cmd.is_last;
            end
            else
            begin
                out_reg.loss    <= sum_sat;
                out_reg.is_last <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_div_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hel_pkg::ST_DIV) |-> (!cmd_pop && !out_load))
        else $error("back consumed or emitted during divide");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hel_pkg::ST_DIV && step_reg == STEP_LAST)
            |=> (state_reg == hel_pkg::ST_HOLD))
        else $error("divide did not end after all steps");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("element count beyond limit");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
    localparam int DRAIN_TAIL  = 64;    // covers the 52-step mean divide plus pipeline
    localparam int BACKLOG_CAP = 16;

    localparam logic [hel_pkg::LOSS_W-1:0] LOSS_MAX = '1;
    localparam logic [hel_pkg::DATA_W-1:0] S32_MIN  = 32'h8000_0000;
    localparam logic [hel_pkg::DATA_W-1:0] S32_MAX  = 32'h7fff_ffff;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [hel_pkg::CFG_INDEX_W-1:0] cfg_index = hel_pkg::CFG_MARGIN;
    logic [hel_pkg::DATA_W-1:0]      cfg_data  = '0;
    logic                            push      = 1'b0;
    logic                            full;
    hel_pkg::hel_in_t                in_item   = '0;
    logic                            empty;
    logic                            pop       = 1'b0;
    hel_pkg::hel_out_t               out_item;

    hinge_embedding_loss_reduce u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Elements waiting to be driven, and losses due from the block in order.
    hel_pkg::hel_in_t  elem_backlog[$];
    hel_pkg::hel_out_t loss_due[$];

    // Shadow of the block: registers as last written, plus the reduction state.
    logic signed [hel_pkg::DATA_W-1:0] margin_set = hel_pkg::MARGIN_RESET;
    logic [1:0]                        mode_set   = hel_pkg::MODE_RESET;
    logic [hel_pkg::LOSS_W-1:0]        acc_sum    = '0;
    logic [hel_pkg::LOSS_W-1:0]        tally      = '0;

    int          bad_count    = 0;
    int          quiet_cycles = 0;
    bit          quiet_mode   = 1'b0;  // no idling on either side while set
    int unsigned send_gap     = 0;
    int unsigned take_gap     = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Hinge loss of one element, then either emit it or fold it into the sum.
    // Sum saturates at all ones, count saturates at MAX_ELEMENTS.
    // Any mode other than none/mean reduces as a plain sum (mode 3 too).
    task automatic fold_element(input hel_pkg::hel_in_t it);
        longint                     diff;
        logic [hel_pkg::LOSS_W-1:0] hinge;
        hel_pkg::hel_out_t          res;
        if (it.target > 0)
            diff = longint'(margin_set) - longint'(it.sample);
        else
            diff = longint'(it.sample);
        hinge = (diff > 0) ? diff[hel_pkg::LOSS_W-1:0] : '0;

        if (mode_set == hel_pkg::MODE_NONE)
        begin
            res.loss    = hinge;
            res.is_last = it.last_element;
            loss_due.push_back(res);
            if (it.last_element)
            begin
                acc_sum = '0;
                tally   = '0;
            end
            return;
        end

        if (acc_sum > LOSS_MAX - hinge)
            acc_sum = LOSS_MAX;
        else
            acc_sum = acc_sum + hinge;
        if (tally < hel_pkg::MAX_ELEMENTS)
            tally = tally + 1'b1;

        if (it.last_element)
        begin
            // count includes this element, never zero here
            res.loss    = (mode_set == hel_pkg::MODE_MEAN) ? acc_sum / tally : acc_sum;
            res.is_last = 1'b1;
            loss_due.push_back(res);
            acc_sum = '0;
            tally   = '0;
        end
    endtask

    task automatic score_result(input hel_pkg::hel_out_t got);
        hel_pkg::hel_out_t want;
        if (loss_due.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: result with nothing due: loss=%h is_last=%b",
                         $realtime, got.loss, got.is_last);
            return;
        end
        want = loss_due.pop_front();
        if (got.loss !== want.loss || got.is_last !== want.is_last)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: result differs: loss want %h got %h, is_last want %b got %b",
                         $realtime, want.loss, got.loss, want.is_last, got.is_last);
        end
    endtask

    // Driver: holds push through full, predicts on every input transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
                fold_element(in_item);
            if (push && full)
            begin
                // stalled: keep item and push as they are
            end
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end
            else if (elem_backlog.size() != 0)
            begin
                in_item  <= elem_backlog.pop_front();
                push     <= 1'b1;
                send_gap <= draw_gap();
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: pop with random stalls, check on every result transfer.
    always @(posedge clk)
    begin
        int unsigned pause;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
                score_result(out_item);
            if (take_gap != 0)
            begin
                take_gap <= take_gap - 1;
                pop      <= 1'b0;
            end
            else if (pop && !empty)
            begin
                pause = draw_gap();
                if (pause == 0)
                    pop <= 1'b1;
                else
                begin
                    pop      <= 1'b0;
                    take_gap <= pause - 1;
                end
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog bookkeeping: cycles since the last transfer on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $realtime, STALL_LIMIT, loss_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send(input logic [hel_pkg::DATA_W-1:0] s,
                        input logic [hel_pkg::DATA_W-1:0] t,
                        input logic last);
        hel_pkg::hel_in_t it;
        while (elem_backlog.size() >= BACKLOG_CAP)
            @(posedge clk);
        it.sample       = s;
        it.target       = t;
        it.last_element = last;
        elem_backlog.push_back(it);
    endtask

    // Sender holds off until every due result is back.
    task automatic drain();
        while (elem_backlog.size() != 0 || push || loss_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then give elements that make no result time to clear the pipe.
    task automatic settle();
        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hel_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hel_pkg::DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == hel_pkg::CFG_MARGIN)
            margin_set = data;
        else
            mode_set = data[1:0];
    endtask

    function automatic logic [hel_pkg::DATA_W-1:0] pick_margin();
        case ($urandom_range(0, 5))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3:       return 32'd65536;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    // Samples cluster near the margin and zero so both hinge sides get hit.
    function automatic logic [hel_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3:       return margin_set + int'($urandom_range(0, 200)) - 100;
            4, 5:    return int'($urandom_range(0, 262144)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [hel_pkg::DATA_W-1:0] pick_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return S32_MIN;
            4:       return S32_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 30);
        return $urandom_range(31, 120);
    endfunction

    initial
    begin
        logic [hel_pkg::DATA_W-1:0] mode_word;
        int                         sent;
        int                         span;
        logic                       tail;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // reset settings: mean, margin 1.0; both hinge sides and target edges
        send(S32_MIN, 32'd1, 1'b0);
        send(S32_MAX, 32'd1, 1'b0);
        send(S32_MAX, 32'd0, 1'b0);
        send(-32'sd5, S32_MIN, 1'b0);
        send(32'd65536, S32_MAX, 1'b1);

        // largest single element loss, mode none with last set
        settle();
        write_reg(hel_pkg::CFG_MARGIN, S32_MAX);
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_NONE});
        send(S32_MIN, S32_MAX, 1'b0);
        send(32'd0, '1, 1'b1);

        // most negative margin: margin side always clamps to zero
        settle();
        write_reg(hel_pkg::CFG_MARGIN, S32_MIN);
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_SUM});
        send(S32_MIN, 32'd5, 1'b0);
        send(S32_MAX, 32'd1, 1'b0);
        send(32'd123456, 32'd0, 1'b1);

        // mode 3 reduces like sum
        settle();
        write_reg(hel_pkg::CFG_MARGIN, 32'd65536);
        write_reg(hel_pkg::CFG_MODE, 32'd3);
        send(32'd0, 32'd1, 1'b0);
        send(-32'sd65536, 32'd1, 1'b1);

        // mode switch mid-tensor: none-mode elements skip the sum,
        // final reduction follows the mode at the last element
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_MEAN});
        send(32'd0, 32'd1, 1'b0);
        send(32'd1000, -32'sd3, 1'b0);
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_NONE});
        send(32'd7, 32'd1, 1'b0);
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_SUM});
        send(32'd70000, '1, 1'b1);

        // last in mode none clears a half-built mean
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_MEAN});
        send(32'd5, 32'd0, 1'b0);
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_NONE});
        send(32'd3, 32'd0, 1'b1);
        settle();
        write_reg(hel_pkg::CFG_MODE, {30'd0, hel_pkg::MODE_MEAN});
        send(32'd8, 32'd0, 1'b1);

        // --- random phases: a fresh setting each phase ---
        for (int ph = 0; ph < 13; ph++)
        begin
            settle();
            write_reg(hel_pkg::CFG_MARGIN, pick_margin());
            mode_word      = $urandom;
            mode_word[1:0] = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
            write_reg(hel_pkg::CFG_MODE, mode_word);
            quiet_mode = (ph % 5 == 3);
            sent       = 0;
            while (sent < 68)
            begin
                span = pick_span();
                for (int k = 0; k < span; k++)
                begin
                    // reduction modes: mostly whole tensors, some stray last bits
                    if (mode_set != hel_pkg::MODE_NONE && $urandom_range(0, 9) != 0)
                        tail = (k == span - 1);
                    else
                        tail = ($urandom_range(0, 99) < 15);
                    send(pick_sample(), pick_target(), tail);
                end
                sent += span;
                if ($urandom_range(0, 99) < 5)
                    drain();
            end
            // sometimes leave a tensor open across the setting change
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send(pick_sample(), pick_target(), 1'b0);
        end

        settle();
        quiet_mode = 1'b0;

        if (bad_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* hinge_embedding_loss_reduce.f */
hw/rtl/hel_pkg.sv
hw/rtl/hel_front.sv
hw/rtl/hel_cmdq.sv
hw/rtl/hel_back.sv
hw/rtl/hinge_embedding_loss_reduce.sv
tb/sv/testbench.sv
